// ===== src/assert_macros.svh =====
// Assertion macros used by the parser RTL.
// In a synthesis build the macros expand to nothing.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

`define ASSERT_ALWAYS(lbl, clk, rstn, expr) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (expr)) \
		else $error("assertion failed");

`define ASSERT_IMPLIES(lbl, clk, rstn, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
		else $error("assertion failed");

`define ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
		else $error("assertion failed");

`else

`define ASSERT_ALWAYS(lbl, clk, rstn, expr)

`define ASSERT_IMPLIES(lbl, clk, rstn, ante, cons)

`define ASSERT_NEXT(lbl, clk, rstn, ante, cons)

`endif

`endif

// ===== src/wsfr_pkg.sv =====
`default_nettype none

package wsfr_pkg;

	localparam int unsigned LEN_W = 20;

	localparam logic [LEN_W-1:0] MAX_LEN_RESET = 20'd4090;

	localparam logic [3:0] OP_TEXT   = 4'd1;
	localparam logic [3:0] OP_BINARY = 4'd2;
	localparam logic [3:0] OP_CLOSE  = 4'd8;

	localparam logic [6:0] LEN7_EXT16 = 7'd126;
	localparam logic [6:0] LEN7_EXT64 = 7'd127;

	localparam logic [2:0] EXT_CNT_16 = 3'd1;
	localparam logic [2:0] EXT_CNT_64 = 3'd7;

	typedef enum logic [1:0] {
		EV_PAYLOAD = 2'd0,
		EV_CLOSE   = 2'd1,
		EV_ERROR   = 2'd2
	} event_t;

	typedef enum logic [2:0] {
		ERR_NO_FIN   = 3'd0,
		ERR_RSV      = 3'd1,
		ERR_UNMASKED = 3'd2,
		ERR_TOO_LONG = 3'd3,
		ERR_OPCODE   = 3'd4
	} err_t;

	typedef enum logic [4:0] {
		PH_HDR0 = 5'b00001,
		PH_HDR1 = 5'b00010,
		PH_EXT  = 5'b00100,
		PH_KEY  = 5'b01000,
		PH_DATA = 5'b10000
	} phase_t;

	typedef struct packed {
		logic       valid;
		event_t     ev;
		logic [7:0] payload;
		logic       text;
		logic       last;
		err_t       code;
	} result_t;

endpackage

`default_nettype wire

// ===== src/wsfr_parser.sv =====
`default_nettype none

`include "assert_macros.svh"

module wsfr_parser import wsfr_pkg::*; (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             step,
	input  wire logic [7:0]       byte_in,
	input  wire logic [LEN_W-1:0] max_len,
	output result_t               res
);

	phase_t           phase_q, phase_d;
	logic [3:0]       opcode_q, opcode_d;
	logic [LEN_W-1:0] len_q, len_d;
	logic             len_hi_q, len_hi_d;
	logic [2:0]       ext_cnt_q, ext_cnt_d;
	logic [31:0]      key_q, key_d;
	logic [LEN_W-1:0] remain_q, remain_d;
	logic [1:0]       midx_q, midx_d;
	logic             halted_q, halted_d;

	logic [LEN_W-1:0] len_shift;
	logic             hi_shift;
	logic [LEN_W-1:0] len7_ext;
	logic [LEN_W-1:0] remain_dec;
	logic [1:0]       midx_inc;
	logic [7:0]       key_byte;

	assign len_shift  = {len_q[LEN_W-9:0], byte_in};
	assign hi_shift   = len_hi_q | (|len_q[LEN_W-1:LEN_W-8]);
	assign len7_ext   = {{(LEN_W-7){1'b0}}, byte_in[6:0]};
	assign remain_dec = remain_q - {{(LEN_W-1){1'b0}}, 1'b1};
	assign midx_inc   = midx_q + 2'd1;

	always_comb begin
		case (midx_q)
			2'd0:    key_byte = key_q[31:24];
			2'd1:    key_byte = key_q[23:16];
			2'd2:    key_byte = key_q[15:8];
			default: key_byte = key_q[7:0];
		endcase
	end

	always_comb begin
		phase_d   = phase_q;
		opcode_d  = opcode_q;
		len_d     = len_q;
		len_hi_d  = len_hi_q;
		ext_cnt_d = ext_cnt_q;
		key_d     = key_q;
		remain_d  = remain_q;
		midx_d    = midx_q;
		halted_d  = halted_q;
		res       = '{valid: 1'b0, ev: EV_PAYLOAD, payload: 8'd0, text: 1'b0,
			last: 1'b0, code: ERR_NO_FIN};
		if (step && !halted_q) begin
			unique case (phase_q)
				PH_HDR1: begin
					len_d    = '0;
					len_hi_d = 1'b0;
					if (!byte_in[7]) begin
						res.valid = 1'b1;
						res.ev    = EV_ERROR;
						res.code  = ERR_UNMASKED;
						halted_d  = 1'b1;
					end else if (byte_in[6:0] == LEN7_EXT16) begin
						ext_cnt_d = EXT_CNT_16;
						phase_d   = PH_EXT;
					end else if (byte_in[6:0] == LEN7_EXT64) begin
						ext_cnt_d = EXT_CNT_64;
						phase_d   = PH_EXT;
					end else if (len7_ext > max_len) begin
						res.valid = 1'b1;
						res.ev    = EV_ERROR;
						res.code  = ERR_TOO_LONG;
						halted_d  = 1'b1;
					end else begin
						len_d   = len7_ext;
						phase_d = PH_KEY;
						midx_d  = 2'd0;
						key_d   = '0;
					end
				end
				PH_EXT: begin
					len_d    = len_shift;
					len_hi_d = hi_shift;
					if (ext_cnt_q == 3'd0) begin
						if (hi_shift || (len_shift > max_len)) begin
							res.valid = 1'b1;
							res.ev    = EV_ERROR;
							res.code  = ERR_TOO_LONG;
							halted_d  = 1'b1;
						end else begin
							phase_d = PH_KEY;
							midx_d  = 2'd0;
							key_d   = '0;
						end
					end else begin
						ext_cnt_d = ext_cnt_q - 3'd1;
					end
				end
				PH_KEY: begin
					key_d  = {key_q[23:0], byte_in};
					midx_d = midx_inc;
					if (midx_inc == 2'd0) begin
						if (len_q == '0) begin
							phase_d = PH_HDR0;
						end else begin
							remain_d = len_q;
							phase_d  = PH_DATA;
						end
					end
				end
				PH_DATA: begin
					midx_d   = midx_inc;
					remain_d = remain_dec;
					if (remain_dec == '0) begin
						phase_d = PH_HDR0;
					end
					if (opcode_q == OP_CLOSE) begin
						if (remain_dec == '0) begin
							res.valid = 1'b1;
							res.ev    = EV_CLOSE;
							halted_d  = 1'b1;
						end
					end else begin
						res.valid   = 1'b1;
						res.ev      = EV_PAYLOAD;
						res.payload = byte_in ^ key_byte;
						res.text    = (opcode_q == OP_TEXT);
						res.last    = (remain_dec == '0);
					end
				end
				default: begin
					// Header byte zero; any unexpected phase code lands here too.
					res.ev = EV_ERROR;
					if (!byte_in[7]) begin
						res.valid = 1'b1;
						res.code  = ERR_NO_FIN;
						halted_d  = 1'b1;
					end else if (byte_in[6:4] != 3'd0) begin
						res.valid = 1'b1;
						res.code  = ERR_RSV;
						halted_d  = 1'b1;
					end else if (byte_in[3:0] != OP_TEXT && byte_in[3:0] != OP_BINARY &&
						byte_in[3:0] != OP_CLOSE) begin
						res.valid = 1'b1;
						res.code  = ERR_OPCODE;
						halted_d  = 1'b1;
					end else begin
						res.ev   = EV_PAYLOAD;
						opcode_d = byte_in[3:0];
						phase_d  = PH_HDR1;
					end
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= PH_HDR0;
			opcode_q  <= '0;
			len_q     <= '0;
			len_hi_q  <= 1'b0;
			ext_cnt_q <= '0;
			key_q     <= '0;
			remain_q  <= '0;
			midx_q    <= '0;
			halted_q  <= 1'b0;
		end else begin
			phase_q   <= phase_d;
			opcode_q  <= opcode_d;
			len_q     <= len_d;
			len_hi_q  <= len_hi_d;
			ext_cnt_q <= ext_cnt_d;
			key_q     <= key_d;
			remain_q  <= remain_d;
			midx_q    <= midx_d;
			halted_q  <= halted_d;
		end
	end

	`ASSERT_NEXT(a_halt_sticky, clk, arst_n, halted_q, halted_q)
	`ASSERT_IMPLIES(a_no_result_halted, clk, arst_n, res.valid, step && !halted_q)
	`ASSERT_NEXT(a_error_halts, clk, arst_n, res.valid && res.ev == EV_ERROR, halted_q)
	`ASSERT_IMPLIES(a_payload_in_data, clk, arst_n,
		res.valid && res.ev == EV_PAYLOAD, phase_q == PH_DATA && opcode_q != OP_CLOSE)

endmodule

`default_nettype wire

// ===== src/wsfr_out_reg.sv =====
`default_nettype none

module wsfr_out_reg import wsfr_pkg::*; (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire result_t    res,
	input  wire logic       out_stall,
	output logic            free,
	output logic            out_valid,
	output logic [1:0]      event_res,
	output logic [7:0]      payload_byte,
	output logic            is_text,
	output logic            last_in_frame,
	output logic [2:0]      error_code
);

	logic    valid_q;
	result_t data_q;

	assign free = !valid_q || !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (free) begin
			valid_q <= res.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (free && res.valid) begin
			data_q <= res;
		end
	end

	assign out_valid     = valid_q;
	assign event_res     = data_q.ev;
	assign payload_byte  = data_q.payload;
	assign is_text       = data_q.text;
	assign last_in_frame = data_q.last;
	assign error_code    = data_q.code;

endmodule

`default_nettype wire

// ===== src/websocket_frame_receiver_core.sv =====
// Channel   Direction  Handshake           Carries
// input     in         in_valid/in_stall   data_byte
// output    out        out_valid/out_stall event_res, payload_byte, is_text,
//                                          last_in_frame, error_code
// config    in         cfg_valid/cfg_ready cfg_data (max_payload_len)
//
// Each byte is captured in the input register and then parsed into the result
// register; a new byte is taken every cycle unless a stalled result holds it.
// The header state, mask key and payload counter update once per byte.
// Reset clears the parser state and sets the length limit to 4090.
// A stalled result holds the result register; the input side then stalls
// once its register is also full.
`default_nettype none

module websocket_frame_receiver_core import wsfr_pkg::*; (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             in_valid,
	output logic                  in_stall,
	input  wire logic [7:0]       data_byte,
	output logic                  out_valid,
	input  wire logic             out_stall,
	output logic [1:0]            event_res,
	output logic [7:0]            payload_byte,
	output logic                  is_text,
	output logic                  last_in_frame,
	output logic [2:0]            error_code,
	input  wire logic             cfg_valid,
	output logic                  cfg_ready,
	input  wire logic [LEN_W-1:0] cfg_data
);

	logic             valid_s1;
	logic [7:0]       byte_s1;
	logic [LEN_W-1:0] max_len_q;
	logic             out_free;
	result_t          res;

	assign cfg_ready = 1'b1;
	assign in_stall  = valid_s1 && !out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_len_q <= MAX_LEN_RESET;
		end else if (cfg_valid && cfg_ready) begin
			max_len_q <= cfg_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			byte_s1 <= data_byte;
		end
	end

	wsfr_parser u_parser (
		.clk     (clk),
		.arst_n  (arst_n),
		.step    (valid_s1 && out_free),
		.byte_in (byte_s1),
		.max_len (max_len_q),
		.res     (res)
	);

	wsfr_out_reg u_out_reg (
		.clk           (clk),
		.arst_n        (arst_n),
		.res           (res),
		.out_stall     (out_stall),
		.free          (out_free),
		.out_valid     (out_valid),
		.event_res     (event_res),
		.payload_byte  (payload_byte),
		.is_text       (is_text),
		.last_in_frame (last_in_frame),
		.error_code    (error_code)
	);

endmodule

`default_nettype wire
